// ===== design/ptt_pkg.sv =====
// ptt_pkg: shared types and constants for the periodic timer table.
// Holds mode and status codes, field widths and the cell control struct.
// No dependencies.
`timescale 1ns / 1ps

package ptt_pkg;

    localparam int MODE_W      = 2;
    localparam int IN_PERIOD_W = 16;
    localparam int STATUS_W    = 3;
    localparam int IDX_W       = 4;
    localparam int TABLE_LIMIT = 2 ** IDX_W;

    localparam int DEF_MAX_ENTRIES = 16;
    localparam int DEF_PERIOD_BITS = 16;

    localparam logic [MODE_W-1:0] MODE_REGISTER = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TICK     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_UNUSED   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_REGISTERED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FIRED      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NONE       = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL       = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_PERIOD = 3'd4;
    localparam logic [STATUS_W-1:0] ST_CLEARED    = 3'd5;

    typedef struct packed {
        logic             load;
        logic [IDX_W-1:0] wr_idx;
        logic             tick;
        logic             clear;
        logic             start;
        logic             advance;
        logic             take;
    } t_cell_ctl;

endpackage

// ===== design/ptt_cell.sv =====
// ptt_cell: one timer entry of the table (reload period, countdown, fire flag).
// Passes the report token to its right neighbour and a fire-pending flag left.
// Depends on ptt_pkg.
`timescale 1ns / 1ps

module ptt_cell #(
    parameter int PERIOD_BITS = ptt_pkg::DEF_PERIOD_BITS,
    parameter int IDX         = 0
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  ptt_pkg::t_cell_ctl     i_ctl,
    input  logic [PERIOD_BITS-1:0] i_period,
    input  logic                   i_tok,
    input  logic                   i_after,
    output logic                   o_tok,
    output logic                   o_any,
    output logic                   o_hit,
    output logic                   o_last_hit
);

    localparam int IW = ptt_pkg::IDX_W;
    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    logic                   r_act;
    logic                   r_fire;
    logic                   r_tok;
    logic [PERIOD_BITS-1:0] r_reload;
    logic [PERIOD_BITS-1:0] r_cnt;
    logic [PERIOD_BITS-1:0] n_cnt;

    assign n_cnt      = r_cnt - PERIOD_BITS'(1);
    assign o_tok      = r_tok;
    assign o_any      = r_fire | i_after;
    assign o_hit      = r_tok & r_fire;
    assign o_last_hit = r_tok & r_fire & ~i_after;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act  <= 1'b0;
            r_fire <= 1'b0;
            r_tok  <= 1'b0;
        end else begin
            if (i_ctl.clear) begin
                r_act <= 1'b0;
            end else if (i_ctl.load && i_ctl.wr_idx == MY_IDX) begin
                r_act <= 1'b1;
            end
            if (i_ctl.tick && r_act && n_cnt == '0) begin
                r_fire <= 1'b1;
            end else if (i_ctl.take && o_hit) begin
                r_fire <= 1'b0;
            end
            if (i_ctl.start) begin
                r_tok <= (IDX == 0);
            end else if (i_ctl.advance) begin
                r_tok <= i_tok;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load && i_ctl.wr_idx == MY_IDX) begin
            r_reload <= i_period;
            r_cnt    <= i_period;
        end else if (i_ctl.tick && r_act) begin
            r_cnt <= (n_cnt == '0) ? r_reload : n_cnt;
        end
    end

endmodule

// ===== design/periodic_timer_table.sv =====
// periodic_timer_table: top level, control sequencer, output register, cell row.
// Instantiates ptt_cell once per table entry. Depends on ptt_pkg.
//
//  channel | valid      | ready      | payload
//  --------+------------+------------+------------------------------------
//  in      | i_in_valid | o_in_ready | i_mode, i_period
//  out     | o_out_valid| i_out_ready| o_status, o_entry_index, o_last
//
// Register, clear and unused-mode beats need no scan. A tick updates every
// entry, then the report token walks the cell row one cell per cycle while
// no found hit waits on a stalled output.
// Synchronous active-low reset empties the table; no clearing pass.
// A stalled result beat holds the token where it is.
`timescale 1ns / 1ps

module periodic_timer_table #(
    parameter int MAX_ENTRIES = ptt_pkg::DEF_MAX_ENTRIES,
    parameter int PERIOD_BITS = ptt_pkg::DEF_PERIOD_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [ptt_pkg::MODE_W-1:0]      i_mode,
    input  logic [ptt_pkg::IN_PERIOD_W-1:0] i_period,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [ptt_pkg::STATUS_W-1:0]    o_status,
    output logic [ptt_pkg::IDX_W-1:0]       o_entry_index,
    output logic                            o_last
);

    localparam int CAP = (MAX_ENTRIES < ptt_pkg::TABLE_LIMIT) ? MAX_ENTRIES
                                                              : ptt_pkg::TABLE_LIMIT;
    localparam int CW  = $clog2(CAP + 1);
    localparam int IW  = ptt_pkg::IDX_W;
    localparam int SW  = ptt_pkg::STATUS_W;
    localparam int PIW = ptt_pkg::IN_PERIOD_W;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic          r_state;
    logic          n_state;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_out_valid;
    logic          n_out_valid;
    logic [SW-1:0] r_status;
    logic [SW-1:0] n_status;
    logic [IW-1:0] r_idx;
    logic [IW-1:0] n_idx;
    logic          r_last;
    logic          n_last;

    logic                   w_out_free;
    logic                   w_in_acc;
    logic [PERIOD_BITS-1:0] w_period;
    logic                   w_full;
    logic                   w_emit;
    logic                   w_none;
    logic                   w_hit_any;
    logic                   w_last_any;
    logic [IW-1:0]          w_hit_idx;
    ptt_pkg::t_cell_ctl     w_ctl;

    logic [CAP-1:0] w_tok;
    logic [CAP-1:0] w_any;
    logic [CAP-1:0] w_hit;
    logic [CAP-1:0] w_lhit;

    generate
        if (PERIOD_BITS >= PIW) begin : g_wide
            assign w_period = PERIOD_BITS'(i_period);
        end else begin : g_sat
            assign w_period = (|i_period[PIW-1:PERIOD_BITS]) ? '1
                                                              : i_period[PERIOD_BITS-1:0];
        end
    endgenerate

    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && w_out_free;
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_full     = (r_count >= CW'(CAP));

    assign w_hit_any  = |w_hit;
    assign w_last_any = |w_lhit;
    assign w_emit     = (r_state == S_SCAN) && w_hit_any && w_out_free;
    assign w_none     = (r_state == S_SCAN) && !w_any[0] && w_out_free;

    always_comb begin
        w_hit_idx = '0;
        for (int i = 0; i < CAP; i++) begin
            if (w_hit[i]) begin
                w_hit_idx = w_hit_idx | IW'(i);
            end
        end
    end

    always_comb begin
        w_ctl.load    = w_in_acc && i_mode == ptt_pkg::MODE_REGISTER
                        && w_period != '0 && !w_full;
        w_ctl.wr_idx  = IW'(r_count);
        w_ctl.tick    = w_in_acc && i_mode == ptt_pkg::MODE_TICK;
        w_ctl.clear   = w_in_acc && i_mode == ptt_pkg::MODE_CLEAR;
        w_ctl.start   = w_ctl.tick;
        w_ctl.advance = (r_state == S_SCAN) && (!w_hit_any || w_emit);
        w_ctl.take    = w_emit;
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAP; gi++) begin : g_cell
            logic w_tok_in;
            logic w_after;
            if (gi == 0) begin : g_first
                assign w_tok_in = 1'b0;
            end else begin : g_mid
                assign w_tok_in = w_tok[gi-1];
            end
            if (gi == CAP - 1) begin : g_end
                assign w_after = 1'b0;
            end else begin : g_inner
                assign w_after = w_any[gi+1];
            end
            ptt_cell #(
                .PERIOD_BITS (PERIOD_BITS),
                .IDX         (gi)
            ) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (w_ctl),
                .i_period   (w_period),
                .i_tok      (w_tok_in),
                .i_after    (w_after),
                .o_tok      (w_tok[gi]),
                .o_any      (w_any[gi]),
                .o_hit      (w_hit[gi]),
                .o_last_hit (w_lhit[gi])
            );
        end
    endgenerate

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_status    = r_status;
        n_idx       = r_idx;
        n_last      = r_last;
        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (w_in_acc) begin
            n_idx  = '0;
            n_last = 1'b1;
            case (i_mode)
                ptt_pkg::MODE_REGISTER: begin
                    n_out_valid = 1'b1;
                    if (w_period == '0) begin
                        n_status = ptt_pkg::ST_BAD_PERIOD;
                    end else if (w_full) begin
                        n_status = ptt_pkg::ST_FULL;
                    end else begin
                        n_status = ptt_pkg::ST_REGISTERED;
                        n_idx    = IW'(r_count);
                        n_count  = r_count + CW'(1);
                    end
                end
                ptt_pkg::MODE_TICK: begin
                    n_state = S_SCAN;
                end
                ptt_pkg::MODE_CLEAR: begin
                    n_out_valid = 1'b1;
                    n_status    = ptt_pkg::ST_CLEARED;
                    n_count     = '0;
                end
                default: begin
                end
            endcase
        end else if (w_emit) begin
            n_out_valid = 1'b1;
            n_status    = ptt_pkg::ST_FIRED;
            n_idx       = w_hit_idx;
            n_last      = w_last_any;
            if (w_last_any) begin
                n_state = S_IDLE;
            end
        end else if (w_none) begin
            n_out_valid = 1'b1;
            n_status    = ptt_pkg::ST_NONE;
            n_idx       = '0;
            n_last      = 1'b1;
            n_state     = S_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_idx    <= n_idx;
        r_last   <= n_last;
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_entry_index = r_idx;
    assign o_last        = r_last;

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAP))
        else $error("entry count beyond table capacity");

    a_tok_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_tok))
        else $error("more than one report token in the cell row");

    a_tick_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.tick |=> r_state == S_SCAN)
        else $error("tick beat did not start a scan");

    a_scan_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |=> $stable(r_count))
        else $error("entry count changed during a scan");

    a_scan_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> !o_in_ready)
        else $error("input beat offered during a scan");

endmodule

// ===== bench/tb_periodic_timer_table.sv =====
// tb_periodic_timer_table: self-checking bench for the periodic timer table.
// Drives register, tick, clear and unused-mode beats and checks every result beat against
// its own table model. Depends on ptt_pkg and periodic_timer_table.
`timescale 1ns / 1ps

class timer_scoreboard;

    typedef struct packed {
        logic [ptt_pkg::STATUS_W-1:0] status;
        logic [ptt_pkg::IDX_W-1:0]    idx;
        logic                         last;
    } t_result;

    localparam int CAP = (ptt_pkg::DEF_MAX_ENTRIES < ptt_pkg::TABLE_LIMIT) ?
                         ptt_pkg::DEF_MAX_ENTRIES : ptt_pkg::TABLE_LIMIT;

    logic [15:0] reloads [16];
    logic [15:0] counts [16];
    int          n_entries;
    t_result     pending_q [$];
    int          errors;

    function new();
        n_entries = 0;
        errors    = 0;
    endfunction

    function void push(logic [ptt_pkg::STATUS_W-1:0] st, int ix, logic lst);
        t_result r;
        r.status = st;
        r.idx    = ix[ptt_pkg::IDX_W-1:0];
        r.last   = lst;
        pending_q.push_back(r);
    endfunction

    function void note_beat(logic [ptt_pkg::MODE_W-1:0] mode,
                            logic [ptt_pkg::IN_PERIOD_W-1:0] period);
        int          fired [$];
        logic [15:0] c;
        case (mode)
            ptt_pkg::MODE_REGISTER: begin
                if (period == 0) begin
                    push(ptt_pkg::ST_BAD_PERIOD, 0, 1'b1);
                end else if (n_entries >= CAP) begin
                    push(ptt_pkg::ST_FULL, 0, 1'b1);
                end else begin
                    reloads[n_entries] = period;
                    counts[n_entries]  = period;
                    push(ptt_pkg::ST_REGISTERED, n_entries, 1'b1);
                    n_entries++;
                end
            end
            ptt_pkg::MODE_TICK: begin
                for (int i = 0; i < n_entries; i++) begin
                    c = counts[i] - 16'd1;
                    if (c == 0) begin
                        c = reloads[i];
                        fired.push_back(i);
                    end
                    counts[i] = c;
                end
                if (fired.size() == 0) begin
                    push(ptt_pkg::ST_NONE, 0, 1'b1);
                end else begin
                    foreach (fired[k])
                        push(ptt_pkg::ST_FIRED, fired[k], k == fired.size() - 1);
                end
            end
            ptt_pkg::MODE_CLEAR: begin
                n_entries = 0;
                push(ptt_pkg::ST_CLEARED, 0, 1'b1);
            end
            default: ;
        endcase
    endfunction

    function void check_beat(logic [ptt_pkg::STATUS_W-1:0] status,
                             logic [ptt_pkg::IDX_W-1:0] idx, logic last);
        t_result e;
        if (pending_q.size() == 0) begin
            $error("unexpected result beat: status %0d index %0d last %0d",
                   status, idx, last);
            errors++;
            return;
        end
        e = pending_q.pop_front();
        if (status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, status);
            errors++;
        end
        if (idx !== e.idx) begin
            $error("entry_index: expected %0d, got %0d", e.idx, idx);
            errors++;
        end
        if (last !== e.last) begin
            $error("last: expected %0d, got %0d", e.last, last);
            errors++;
        end
    endfunction

    function int outstanding();
        return pending_q.size();
    endfunction

endclass

module tb_periodic_timer_table;

    localparam int TB_CAP = (ptt_pkg::DEF_MAX_ENTRIES < ptt_pkg::TABLE_LIMIT) ?
                            ptt_pkg::DEF_MAX_ENTRIES : ptt_pkg::TABLE_LIMIT;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_in_valid;
    logic                            o_in_ready;
    logic [ptt_pkg::MODE_W-1:0]      i_mode;
    logic [ptt_pkg::IN_PERIOD_W-1:0] i_period;
    logic                            o_out_valid;
    logic                            i_out_ready;
    logic [ptt_pkg::STATUS_W-1:0]    o_status;
    logic [ptt_pkg::IDX_W-1:0]       o_entry_index;
    logic                            o_last;

    timer_scoreboard sb;
    bit              calm;
    int              hold_left;

    periodic_timer_table i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_mode        (i_mode),
        .i_period      (i_period),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_entry_index (o_entry_index),
        .o_last        (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2ms;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic bit take_break();
        return !calm && ($urandom_range(0, 99) < 33);
    endfunction

    // one beat on the input channel; returns once it has been accepted
    task automatic send_beat(input logic [ptt_pkg::MODE_W-1:0] m,
                             input logic [ptt_pkg::IN_PERIOD_W-1:0] p);
        @(negedge i_clk);
        while (take_break()) begin
            i_in_valid <= 1'b0;
            i_mode     <= 2'($urandom);
            i_period   <= 16'($urandom);
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode     <= m;
        i_period   <= p;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic send_random_beat();
        int          r;
        int          pr;
        logic [15:0] p;
        r  = $urandom_range(0, 99);
        pr = $urandom_range(0, 99);
        if (pr < 65)      p = 16'($urandom_range(1, 5));
        else if (pr < 82) p = 16'($urandom_range(1, 40));
        else if (pr < 95) p = 16'($urandom);
        else              p = 16'd0;
        if (r < 45)      send_beat(ptt_pkg::MODE_REGISTER, p);
        else if (r < 88) send_beat(ptt_pkg::MODE_TICK, 16'($urandom));
        else             send_beat(ptt_pkg::MODE_CLEAR, 16'($urandom));
    endtask

    // receiver: random back-pressure, plus a counted hold-off on request
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_out_ready <= 1'b0;
                hold_left = hold_left - 1;
            end else begin
                i_out_ready <= !take_break();
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                sb.note_beat(i_mode, i_period);
            if (o_out_valid && i_out_ready)
                sb.check_beat(o_status, o_entry_index, o_last);
        end
    end

    initial begin
        int n;
        sb         = new();
        calm       = 1'b0;
        hold_left  = 0;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_mode     = ptt_pkg::MODE_REGISTER;
        i_period   = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed
        send_beat(ptt_pkg::MODE_TICK, 16'h0000);
        send_beat(ptt_pkg::MODE_REGISTER, 16'h0000);
        send_beat(ptt_pkg::MODE_REGISTER, 16'h0001);
        send_beat(ptt_pkg::MODE_REGISTER, 16'hFFFF);
        send_beat(ptt_pkg::MODE_TICK, 16'hFFFF);
        send_beat(ptt_pkg::MODE_UNUSED, 16'hFFFF);
        send_beat(ptt_pkg::MODE_CLEAR, 16'h0000);
        for (int i = 0; i < TB_CAP; i++)
            send_beat(ptt_pkg::MODE_REGISTER, 16'd1);
        send_beat(ptt_pkg::MODE_REGISTER, 16'd5);
        send_beat(ptt_pkg::MODE_REGISTER, 16'd0);
        send_beat(ptt_pkg::MODE_TICK, 16'h0000);
        send_beat(ptt_pkg::MODE_CLEAR, 16'hFFFF);

        // random
        n = 0;
        while (n < 200) begin
            if (n == 30)
                hold_left = 300;
            calm = (n >= 90 && n < 130);
            if ($urandom_range(0, 99) < 3) begin
                send_beat(ptt_pkg::MODE_UNUSED, 16'($urandom));
            end else begin
                send_random_beat();
                n++;
            end
        end
        calm = 1'b0;
        @(negedge i_clk);
        i_in_valid <= 1'b0;

        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/ptt_pkg.sv
design/ptt_cell.sv
design/periodic_timer_table.sv
bench/tb_periodic_timer_table.sv
